### rtl/mfd_pkg.sv
package mfd_pkg;

  // field widths of the channel words
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned SLOT_W = 4;

  // defaults for the top-level parameters
  localparam int unsigned NUM_SLOTS_DEF = 10;
  localparam int unsigned MAX_FRAME_DEF = 280;

  // request codes
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // protocol constants
  localparam logic [BYTE_W-1:0] STX_V1        = 8'hFE;
  localparam logic [BYTE_W-1:0] STX_V2        = 8'hFD;
  localparam logic [BYTE_W-1:0] INCOMPAT_SIGN = 8'h01;

  // framing overhead in bytes
  localparam logic [9:0] OVH_V1        = 10'd8;
  localparam logic [9:0] OVH_V2        = 10'd12;
  localparam logic [9:0] OVH_V2_SIGNED = 10'd25;

  // byte positions of the length and flags fields, and the first position that can close a frame
  localparam logic [POS_W-1:0] POS_LEN   = 9'd1;
  localparam logic [POS_W-1:0] POS_FLAGS = 9'd2;
  localparam logic [POS_W-1:0] POS_BODY  = 9'd3;

  typedef struct packed {
    logic              alloc;
    logic              release_en;
    logic [SLOT_W-1:0] release_slot;
  } alloc_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              overwritten;
  } alloc_rsp_t;

endpackage

### rtl/mfd_if.sv
interface mfd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [mfd_pkg::BYTE_W-1:0]  data_byte;
  logic [mfd_pkg::SLOT_W-1:0]  release_slot;

  modport source (output valid, output req_type, output data_byte, output release_slot,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input release_slot,
                  output ready);
endinterface

interface mfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mfd_pkg::BYTE_W-1:0]  frame_byte;
  logic [mfd_pkg::POS_W-1:0]   byte_position;
  logic                        last_byte;
  logic [mfd_pkg::SLOT_W-1:0]  slot;
  logic                        slot_overwritten;

  modport source (output valid, output frame_byte, output byte_position,
                  output last_byte, output slot, output slot_overwritten,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input last_byte, input slot, input slot_overwritten,
                  output ready);
endinterface

### rtl/mfd_slot_alloc.sv
module mfd_slot_alloc #(
  parameter int unsigned NUM_SLOTS = mfd_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mfd_pkg::alloc_req_t req,
  output mfd_pkg::alloc_rsp_t rsp
);

  logic [NUM_SLOTS-1:0] slot_busy;
  logic [NUM_SLOTS-1:0] slot_busy_next;
  logic [NUM_SLOTS-1:0] pick_mask;
  logic                 found;

  // lowest free slot; last slot when the map is full
  always_comb begin
    found     = 1'b0;
    pick_mask = '0;
    rsp.slot  = mfd_pkg::SLOT_W'(NUM_SLOTS - 1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && !slot_busy[i]) begin
        found        = 1'b1;
        pick_mask[i] = 1'b1;
        rsp.slot     = mfd_pkg::SLOT_W'(i);
      end
    end
    if (!found) begin
      pick_mask[NUM_SLOTS-1] = 1'b1;
    end
    rsp.overwritten = !found;
  end

  always_comb begin
    slot_busy_next = slot_busy;
    if (req.alloc) begin
      slot_busy_next = slot_busy | pick_mask;
    end
    if (req.release_en) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (32'(req.release_slot) == i) begin
          slot_busy_next[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
    end else begin
      slot_busy <= slot_busy_next;
    end
  end

endmodule

### rtl/mavlink_frame_deframer.sv
// A frame byte is registered and shows on the output in the cycle after it is accepted.
// Throughput: one word per cycle; a word is taken whenever the output register
//   is empty or is being drained in the same cycle.
// Release words and stray bytes outside a frame produce no output word.
// Reset (rst, synchronous, active high): idle, position 0, all slots free,
//   output register empty.
module mavlink_frame_deframer #(
  parameter int unsigned NUM_SLOTS = mfd_pkg::NUM_SLOTS_DEF,
  parameter int unsigned MAX_FRAME = mfd_pkg::MAX_FRAME_DEF
) (
  input logic      clk,
  input logic      rst,
  mfd_in_if.sink   inp,
  mfd_out_if.source outp
);

  // framing state
  logic                         in_frame,    in_frame_next;
  logic [mfd_pkg::POS_W-1:0]    position,    position_next;
  logic [mfd_pkg::POS_W-1:0]    frame_total, frame_total_next;
  logic                         is_v2,       is_v2_next;
  logic [mfd_pkg::BYTE_W-1:0]   payload_len, payload_len_next;

  logic                         accept;
  logic                         emit;
  logic                         last;
  logic [mfd_pkg::POS_W-1:0]    pos_out;
  logic [9:0]                   total_raw;
  logic [9:0]                   total_cap;
  logic [9:0]                   pos_plus1;
  logic                         is_byte;
  logic                         is_stx;

  mfd_pkg::alloc_req_t          alloc_req;
  mfd_pkg::alloc_rsp_t          alloc_rsp;

  // output register frees the input side as soon as it drains
  assign inp.ready = !outp.valid || outp.ready;
  assign accept    = inp.valid && inp.ready;

  assign is_byte = (inp.req_type == mfd_pkg::REQ_BYTE);
  assign is_stx  = (inp.data_byte == mfd_pkg::STX_V1) || (inp.data_byte == mfd_pkg::STX_V2);

  // total length from the payload length (byte 1) and the incompat flags (byte 2)
  always_comb begin
    if (!is_v2) begin
      total_raw = 10'(payload_len) + mfd_pkg::OVH_V1;
    end else if ((inp.data_byte & mfd_pkg::INCOMPAT_SIGN) != '0) begin
      total_raw = 10'(payload_len) + mfd_pkg::OVH_V2_SIGNED;
    end else begin
      total_raw = 10'(payload_len) + mfd_pkg::OVH_V2;
    end
    total_cap = (total_raw > 10'(MAX_FRAME)) ? 10'(MAX_FRAME) : total_raw;
  end

  assign pos_plus1 = 10'(position) + 10'd1;

  always_comb begin
    in_frame_next    = in_frame;
    position_next    = position;
    frame_total_next = frame_total;
    is_v2_next       = is_v2;
    payload_len_next = payload_len;
    emit             = 1'b0;
    last             = 1'b0;
    pos_out          = position;

    if (is_byte) begin
      if (!in_frame) begin
        // hunt for a start byte, drop anything else
        if (is_stx) begin
          emit          = 1'b1;
          in_frame_next = 1'b1;
          is_v2_next    = (inp.data_byte == mfd_pkg::STX_V2);
          position_next = 9'd1;
          pos_out       = '0;
        end
      end else begin
        emit = 1'b1;
        if (position == mfd_pkg::POS_LEN) begin
          payload_len_next = inp.data_byte;
        end else if (position == mfd_pkg::POS_FLAGS) begin
          frame_total_next = total_cap[mfd_pkg::POS_W-1:0];
        end else if (position >= mfd_pkg::POS_BODY && pos_plus1 >= 10'(frame_total)) begin
          last = 1'b1;
        end
        if (last) begin
          in_frame_next = 1'b0;
          position_next = '0;
        end else begin
          position_next = pos_plus1[mfd_pkg::POS_W-1:0];
        end
      end
    end
  end

  // slot map: allocate on the closing byte, free on a release word
  always_comb begin
    alloc_req.alloc        = accept && last;
    alloc_req.release_en   = accept && (inp.req_type == mfd_pkg::REQ_RELEASE);
    alloc_req.release_slot = inp.release_slot;
  end

  mfd_slot_alloc #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_alloc (
    .clk (clk),
    .rst (rst),
    .req (alloc_req),
    .rsp (alloc_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      position    <= '0;
      frame_total <= '0;
      is_v2       <= 1'b0;
      payload_len <= '0;
    end else if (accept) begin
      in_frame    <= in_frame_next;
      position    <= position_next;
      frame_total <= frame_total_next;
      is_v2       <= is_v2_next;
      payload_len <= payload_len_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      outp.valid <= 1'b0;
    end else if (inp.ready) begin
      outp.valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      outp.frame_byte       <= inp.data_byte;
      outp.byte_position    <= pos_out;
      outp.last_byte        <= last;
      outp.slot             <= last ? alloc_rsp.slot : '0;
      outp.slot_overwritten <= last && alloc_rsp.overwritten;
    end
  end

  // a frame never closes before its header is in
  a_last_after_header: assert property (@(posedge clk) disable iff (rst)
    outp.valid && outp.last_byte |-> outp.byte_position >= mfd_pkg::POS_BODY)
    else $error("frame closed inside header");

  // slot fields stay zero on bytes that do not close a frame
  a_slot_only_on_last: assert property (@(posedge clk) disable iff (rst)
    outp.valid && !outp.last_byte |-> outp.slot == '0 && !outp.slot_overwritten)
    else $error("slot reported on non-closing byte");

  // an overwrite always reuses the last slot
  a_overwrite_last_slot: assert property (@(posedge clk) disable iff (rst)
    outp.valid && outp.slot_overwritten |-> outp.slot == mfd_pkg::SLOT_W'(NUM_SLOTS - 1))
    else $error("overwrite on wrong slot");

  // position zero is always a start byte
  a_pos0_is_stx: assert property (@(posedge clk) disable iff (rst)
    outp.valid && outp.byte_position == '0 |->
      outp.frame_byte == mfd_pkg::STX_V1 || outp.frame_byte == mfd_pkg::STX_V2)
    else $error("frame opened without start byte");

  // idle hunter keeps the position counter cleared
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> position == '0)
    else $error("position nonzero while idle");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NUM_SLOTS    = mfd_pkg::NUM_SLOTS_DEF;
  localparam int unsigned MAX_FRAME    = mfd_pkg::MAX_FRAME_DEF;
  localparam int          PERIOD       = 20;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          STALL_CYCLES = 300;  // long receiver hold-off
  localparam int          TARGET_WORDS = 1450; // input words to push through
  localparam int          TAIL_CYCLES  = 8;    // output register is one stage deep

  // One output word as the block presents it.
  typedef struct packed {
    logic [mfd_pkg::BYTE_W-1:0] frame_byte;
    logic [mfd_pkg::POS_W-1:0]  byte_position;
    logic                       last_byte;
    logic [mfd_pkg::SLOT_W-1:0] slot;
    logic                       slot_overwritten;
  } frame_word_t;

  // Tracks the frame delimiter state and the slot map, and keeps the queue
  // of frame words still owed by the block.
  class deframe_scoreboard;
    bit                         framing;
    logic [mfd_pkg::POS_W-1:0]  cur_pos;
    int                         frame_len;
    bit                         v2_frame;
    logic [mfd_pkg::BYTE_W-1:0] pay_len;
    logic [NUM_SLOTS-1:0]       slot_taken;
    frame_word_t                owed[$];
    int errors, expected_total, checked, frames_closed, overwrites, releases, strays;
    int accepted;

    function void clear();
      framing    = 1'b0;
      cur_pos    = '0;
      frame_len  = 0;
      v2_frame   = 1'b0;
      pay_len    = '0;
      slot_taken = '0;
      owed.delete();
    endfunction

    // Accepted input word: advance the delimiter and queue any frame word.
    function void note_word(logic rq, logic [mfd_pkg::BYTE_W-1:0] b,
                            logic [mfd_pkg::SLOT_W-1:0] rel);
      frame_word_t w;
      int          pick;
      accepted++;
      if (rq == mfd_pkg::REQ_RELEASE) begin
        releases++;
        if (rel < NUM_SLOTS) slot_taken[rel] = 1'b0;
        return;
      end
      w = '0;
      w.frame_byte = b;
      if (!framing) begin
        if (b != mfd_pkg::STX_V1 && b != mfd_pkg::STX_V2) begin
          strays++;
          return;
        end
        framing  = 1'b1;
        v2_frame = (b == mfd_pkg::STX_V2);
        cur_pos  = mfd_pkg::POS_LEN;
        owed.push_back(w);
        expected_total++;
        return;
      end
      w.byte_position = cur_pos;
      if (cur_pos == mfd_pkg::POS_LEN) begin
        pay_len = b;
      end else if (cur_pos == mfd_pkg::POS_FLAGS) begin
        if (!v2_frame) frame_len = int'(mfd_pkg::OVH_V1);
        else if ((b & mfd_pkg::INCOMPAT_SIGN) != 0) frame_len = int'(mfd_pkg::OVH_V2_SIGNED);
        else frame_len = int'(mfd_pkg::OVH_V2);
        frame_len += int'(pay_len);
        if (frame_len > int'(MAX_FRAME)) frame_len = int'(MAX_FRAME);
      end else if (cur_pos >= mfd_pkg::POS_BODY && int'(cur_pos) + 1 >= frame_len) begin
        w.last_byte = 1'b1;
        if (&slot_taken) begin
          pick = int'(NUM_SLOTS) - 1;
          w.slot_overwritten = 1'b1;
          overwrites++;
        end else begin
          pick = 0;
          for (int i = int'(NUM_SLOTS) - 1; i >= 0; i--)
            if (!slot_taken[i]) pick = i;
        end
        w.slot = pick[mfd_pkg::SLOT_W-1:0];
        slot_taken[pick] = 1'b1;
        frames_closed++;
      end
      owed.push_back(w);
      expected_total++;
      if (w.last_byte) begin
        framing = 1'b0;
        cur_pos = '0;
      end else begin
        cur_pos = cur_pos + 1'b1;
      end
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      checked++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected frame word, expected none actual byte %0h pos %0d",
                 $time, got.frame_byte, got.byte_position);
        errors++;
        return;
      end
      want = owed.pop_front();
      cmp_field("frame_byte", want.frame_byte, got.frame_byte);
      cmp_field("byte_position", want.byte_position, got.byte_position);
      cmp_field("last_byte", want.last_byte, got.last_byte);
      cmp_field("slot", want.slot, got.slot);
      cmp_field("slot_overwritten", want.slot_overwritten, got.slot_overwritten);
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mfd_in_if  byte_ch ();
  mfd_out_if frame_ch ();

  mavlink_frame_deframer #(
    .NUM_SLOTS(NUM_SLOTS),
    .MAX_FRAME(MAX_FRAME)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .inp (byte_ch.sink),
    .outp(frame_ch.source)
  );

  always #(PERIOD / 2) clk = ~clk;

  deframe_scoreboard sb;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int stall_req    = 0;  // bumped by the stimulus to ask for a long hold-off
  int stall_seen   = 0;
  int hold_left    = 0;
  int cycles       = 0;

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: check each drained word, then pick ready for the next edge.
  // A stall request loads a hold-off counter that this process runs down.
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready)
        sb.check_word('{frame_ch.frame_byte, frame_ch.byte_position, frame_ch.last_byte,
                        frame_ch.slot, frame_ch.slot_overwritten});
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold it until taken.
  // Valid stays high into the next call unless that call idles first.
  task automatic send_word(input logic rq, input logic [mfd_pkg::BYTE_W-1:0] b,
                           input logic [mfd_pkg::SLOT_W-1:0] rel);
    while ($urandom_range(99) < send_gap_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.req_type     <= rq;
    byte_ch.data_byte    <= b;
    byte_ch.release_slot <= rel;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sb.note_word(rq, b, rel);
  endtask

  // Serial byte; the unused slot field gets noise.
  task automatic send_byte(input logic [mfd_pkg::BYTE_W-1:0] b);
    send_word(mfd_pkg::REQ_BYTE, b, mfd_pkg::SLOT_W'($urandom));
  endtask

  // Slot release; the unused byte field gets noise.
  task automatic send_release(input int rel);
    send_word(mfd_pkg::REQ_RELEASE, mfd_pkg::BYTE_W'($urandom), rel[mfd_pkg::SLOT_W-1:0]);
  endtask

  // Well-formed frame with random content; releases are sprinkled in now and then.
  task automatic send_frame(input bit v2, input bit signed_f, input int plen);
    int                         total;
    logic [mfd_pkg::BYTE_W-1:0] flags;
    if (!v2) total = int'(mfd_pkg::OVH_V1);
    else if (signed_f) total = int'(mfd_pkg::OVH_V2_SIGNED);
    else total = int'(mfd_pkg::OVH_V2);
    total += plen;
    send_byte(v2 ? mfd_pkg::STX_V2 : mfd_pkg::STX_V1);
    send_byte(plen[mfd_pkg::BYTE_W-1:0]);
    flags = mfd_pkg::BYTE_W'($urandom);
    if (v2) begin
      flags = signed_f ? (flags | mfd_pkg::INCOMPAT_SIGN) : (flags & ~mfd_pkg::INCOMPAT_SIGN);
    end
    send_byte(flags);
    for (int i = 3; i < total; i++) begin
      if ($urandom_range(99) < 4) send_release($urandom_range(15));
      send_byte(mfd_pkg::BYTE_W'($urandom));
    end
  endtask

  // Sender pause: nothing offered until every owed word has drained.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int pick;
    int plen;

    sb = new();
    sb.clear();
    rst                  = 1'b1;
    byte_ch.valid        = 1'b0;
    byte_ch.req_type     = mfd_pkg::REQ_BYTE;
    byte_ch.data_byte    = '0;
    byte_ch.release_slot = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct <= 29;
    recv_gap_pct <= 84;
    @(posedge clk);

    // Directed: stray bytes while idle, release out of range and of a free slot.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_release(15);
    send_release(3);
    // Shortest v1 frame; start codes inside it are plain payload.
    send_byte(mfd_pkg::STX_V1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(mfd_pkg::STX_V1);
    send_byte(mfd_pkg::STX_V2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    // Shortest unsigned v2 frame with slot 0 released in mid-flight,
    // so it is handed slot 0 again.
    send_byte(mfd_pkg::STX_V2);
    send_byte(8'h00);
    send_byte(8'hFE);
    for (int i = 3; i < int'(mfd_pkg::OVH_V2); i++) begin
      if (i == 6) send_release(0);
      send_byte(mfd_pkg::BYTE_W'($urandom));
    end

    // Random traffic: mostly frames, some noise and broken byte runs.
    phase = 1;
    while (sb.accepted < TARGET_WORDS) begin
      if (phase == 1 && sb.accepted >= TARGET_WORDS / 3) begin
        wait_drained();
        send_gap_pct <= 84;
        recv_gap_pct <= 29;
        phase = 2;
      end else if (phase == 2 && sb.accepted >= 2 * TARGET_WORDS / 3) begin
        wait_drained();
        send_gap_pct <= 0;
        recv_gap_pct <= 0;
        phase = 3;
        // Longest frame pushed into a long receiver hold-off: the output
        // register fills and the input has to back up.
        stall_req++;
        send_frame(1'b1, 1'b1, 255);
        wait_drained();
      end

      pick = $urandom_range(99);
      if (pick < 8) begin
        // stray bytes between frames, never a start code
        repeat ($urandom_range(1, 4)) begin
          plen = $urandom_range(255);
          if (plen == mfd_pkg::STX_V1 || plen == mfd_pkg::STX_V2) plen = 0;
          send_byte(plen[mfd_pkg::BYTE_W-1:0]);
        end
      end else if (pick < 12) begin
        // broken run: byte soup rich in start codes, then finish whatever it opened
        repeat ($urandom_range(5, 30)) begin
          case ($urandom_range(3))
            0: send_byte(mfd_pkg::STX_V1);
            1: send_byte(mfd_pkg::STX_V2);
            default: send_byte(mfd_pkg::BYTE_W'($urandom));
          endcase
        end
        while (sb.framing) send_byte(mfd_pkg::BYTE_W'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 85) plen = $urandom_range(16);
        else if (pick < 98) plen = $urandom_range(17, 80);
        else plen = $urandom_range(200, 255);
        send_frame(1'($urandom_range(1)), 1'($urandom_range(1)), plen);
      end

      // Releases between frames; now and then the whole map is cleared.
      if ($urandom_range(99) < 50)
        repeat ($urandom_range(1, 2)) send_release($urandom_range(15));
      if ($urandom_range(99) < 4)
        for (int s = 0; s < int'(NUM_SLOTS); s++) send_release(s);
    end

    wait_drained();
    if (sb.pending() != 0) begin
      $display("%0d frame words never arrived", sb.pending());
      sb.errors += sb.pending();
    end

    $display("Checked %0d frame words over %0d frames (%0d with no free slot).",
             sb.checked, sb.frames_closed, sb.overwrites);
    $display("Also sent %0d slot releases and %0d stray bytes; %0d errors.",
             sb.releases, sb.strays, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mfd_pkg.sv
rtl/mfd_if.sv
rtl/mfd_slot_alloc.sv
rtl/mavlink_frame_deframer.sv
verif/testbench.sv
